// ----- design/ntpts_pkg.sv -----
// ntpts_pkg: shared types and constants for the ntp response time sync block
// holds the input and result word structs, opcode and status codes, register map
// no dependencies
package ntpts_pkg;

  // register map
  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-3:0] RegMinUnix = 1'b0;
  localparam logic [31:0] MinUnixReset = 32'd946684800;

  // time conversion constants
  localparam logic [31:0] EpochGapSeconds = 32'd2208988800;
  localparam logic [19:0] MicrosPerSecond = 20'd1000000;

  // packet layout
  localparam logic [5:0] PacketBytes  = 6'd48;
  localparam logic [5:0] ModeByte     = 6'd0;
  localparam logic [5:0] SecondsFirst = 6'd40;
  localparam logic [5:0] SecondsLast  = 6'd43;
  localparam logic [5:0] FracFirst    = 6'd44;
  localparam logic [5:0] FracLast     = 6'd47;
  localparam logic [2:0] ServerMode   = 3'd4;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_BYTE     = 2'd2,
    OP_QUERY    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_SYNCED    = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_MODE  = 3'd3,
    ST_TOO_OLD   = 3'd4
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [63:0] local_micros;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic        is_synced;
    logic [63:0] packet_micros;
    logic [63:0] server_micros_at_sync;
    logic [63:0] local_micros_at_sync;
    logic [63:0] server_micros_now;
    logic [63:0] round_trip_micros;
  } out_word_t;

endpackage

// ----- design/ntp_response_time_sync.sv -----
// ntp_response_time_sync: sntp client time sync from timestamped events
// depends on ntpts_pkg for word structs, codes and constants
//
// usage
//   in channel (in_valid_i / in_ready_o / in_word_i) takes one event word per cycle
//   while in_ready_o is high: request sent, response interrupt, one received packet
//   byte (with last flag) or a time query. every word gives exactly one result word
//   on the out channel (out_valid_o / out_ready_i / out_word_o), in order.
//   a packet of at least 48 bytes with server mode in byte 0 and a transmit time no
//   older than min_unix_seconds updates the sync point; the result reports status
//   and the estimated server time now.
// pipeline and throughput
//   three register stages: input word, state update, result word. a word goes from
//   the input stage through the middle stage to out_word_o. one word per cycle is
//   sustained while out_ready_i is high; the word behind reads the updated sync state.
//   the seconds product is registered from the seconds word and the fraction product
//   is built one byte at a time, so the packet end needs only adds.
// stalls and reset
//   when the receiver holds out_ready_i low the result word holds, the stages behind
//   fill, and in_ready_o drops once the input stage cannot move on. reset empties all
//   stages, clears the sync state and sets min_unix_seconds to 946684800. the user
//   writes the apb register (byte address 0) only while idle; the block does not check.
module ntp_response_time_sync
  import ntpts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // event words
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // ---------------------------------------------------------------- config
  logic [31:0] min_unix_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_unix_q <= MinUnixReset;
    end else if (cfg_wr && paddr[AddrW-1:2] == RegMinUnix) begin
      min_unix_q <= pwdata;
    end
  end

  always_comb begin
    if (paddr[AddrW-1:2] == RegMinUnix) begin
      prdata = min_unix_q;
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic a_vld_q, b_vld_q, c_vld_q;
  logic c_free, b_free, a_free;
  logic a_adv, b_adv;

  assign c_free     = !c_vld_q || out_ready_i;
  assign b_adv      = b_vld_q && c_free;
  assign b_free     = !b_vld_q || c_free;
  assign a_adv      = a_vld_q && b_free;
  assign a_free     = !a_vld_q || b_free;
  assign in_ready_o = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_q <= in_valid_i;
      end
      if (b_free) begin
        b_vld_q <= a_vld_q;
      end
      if (c_free) begin
        c_vld_q <= b_vld_q;
      end
    end
  end

  // input stage
  in_word_t a_word_q;

  always_ff @(posedge clk_i) begin
    if (a_free && in_valid_i) begin
      a_word_q <= in_word_i;
    end
  end

  // ---------------------------------------------------------------- sync state
  logic [5:0]  cnt_q, cnt_d;
  logic        mode_ok_q, mode_ok_d;
  logic [31:0] sec_word_q, sec_word_d;
  logic [51:0] frac_prod_q, frac_prod_d;   // fraction bytes so far times one million
  logic [63:0] req_q, req_d;
  logic [63:0] resp_q, resp_d;
  logic [63:0] rtt_q, rtt_d;               // resp minus req, kept current
  logic [63:0] srv_q, srv_d;
  logic [63:0] loc_q, loc_d;
  logic [63:0] sync_rtt_q, sync_rtt_d;
  logic        synced_q, synced_d;
  logic [51:0] sec_us_q;                   // unix seconds times one million

  logic [31:0] unix_secs;
  logic [27:0] byte_us;
  status_e     status_d;
  logic [63:0] packet_us_d;

  assign unix_secs = sec_word_q - EpochGapSeconds;
  assign byte_us   = 28'(a_word_q.data_byte) * 28'(MicrosPerSecond);

  always_comb begin
    cnt_d       = cnt_q;
    mode_ok_d   = mode_ok_q;
    sec_word_d  = sec_word_q;
    frac_prod_d = frac_prod_q;
    req_d       = req_q;
    resp_d      = resp_q;
    rtt_d       = rtt_q;
    srv_d       = srv_q;
    loc_d       = loc_q;
    sync_rtt_d  = sync_rtt_q;
    synced_d    = synced_q;
    status_d    = ST_NONE;
    packet_us_d = '0;
    unique case (a_word_q.opcode)
      OP_REQUEST: begin
        req_d = a_word_q.local_micros;
        rtt_d = resp_q - a_word_q.local_micros;
      end
      OP_RESPONSE: begin
        resp_d = a_word_q.local_micros;
        rtt_d  = a_word_q.local_micros - req_q;
      end
      OP_BYTE: begin
        if (cnt_q < PacketBytes) begin
          if (cnt_q == ModeByte) begin
            mode_ok_d = (a_word_q.data_byte[2:0] == ServerMode);
          end
          if (cnt_q >= SecondsFirst && cnt_q <= SecondsLast) begin
            sec_word_d = {sec_word_q[23:0], a_word_q.data_byte};
          end
          if (cnt_q >= FracFirst && cnt_q <= FracLast) begin
            frac_prod_d = {frac_prod_q[43:0], 8'h00} + 52'(byte_us);
          end
          cnt_d = cnt_q + 6'd1;
        end
        if (a_word_q.last_byte) begin
          if (cnt_d < PacketBytes) begin
            status_d = ST_SHORT;
          end else if (!mode_ok_d) begin
            status_d = ST_BAD_MODE;
          end else if (unix_secs < min_unix_q) begin
            status_d = ST_TOO_OLD;
          end else begin
            packet_us_d = 64'(sec_us_q) + 64'(frac_prod_d[51:32]);
            srv_d       = packet_us_d + {1'b0, rtt_q[63:1]};
            loc_d       = resp_q;
            sync_rtt_d  = rtt_q;
            synced_d    = 1'b1;
            status_d    = ST_SYNCED;
          end
          // packet closed, start over
          cnt_d       = '0;
          mode_ok_d   = 1'b0;
          sec_word_d  = '0;
          frac_prod_d = '0;
        end
      end
      OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mode_ok_q   <= 1'b0;
      sec_word_q  <= '0;
      frac_prod_q <= '0;
      req_q       <= '0;
      resp_q      <= '0;
      rtt_q       <= '0;
      srv_q       <= '0;
      loc_q       <= '0;
      sync_rtt_q  <= '0;
      synced_q    <= 1'b0;
    end else if (a_adv) begin
      cnt_q       <= cnt_d;
      mode_ok_q   <= mode_ok_d;
      sec_word_q  <= sec_word_d;
      frac_prod_q <= frac_prod_d;
      req_q       <= req_d;
      resp_q      <= resp_d;
      rtt_q       <= rtt_d;
      srv_q       <= srv_d;
      loc_q       <= loc_d;
      sync_rtt_q  <= sync_rtt_d;
      synced_q    <= synced_d;
    end
  end

  // seconds product is registered from the seconds word; the packet end is at
  // least four bytes after the last seconds byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_us_q <= '0;
    end else begin
      sec_us_q <= 52'(unix_secs) * 52'(MicrosPerSecond);
    end
  end

  // ---------------------------------------------------------------- middle stage
  status_e     b_status_q;
  logic [63:0] b_packet_q;
  logic [63:0] b_now_q;

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_status_q <= status_d;
      b_packet_q <= packet_us_d;
      b_now_q    <= a_word_q.local_micros;
    end
  end

  // ---------------------------------------------------------------- result stage
  // the sync state already holds this word's update while it sits in the middle stage
  out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_q.status                <= b_status_q;
      out_q.is_synced             <= synced_q;
      out_q.packet_micros         <= b_packet_q;
      out_q.server_micros_at_sync <= srv_q;
      out_q.local_micros_at_sync  <= loc_q;
      out_q.server_micros_now     <= synced_q ? srv_q + (b_now_q - loc_q) : '0;
      out_q.round_trip_micros     <= sync_rtt_q;
    end
  end

  assign out_valid_o = c_vld_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------- checks
  a_synced_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_SYNCED |-> out_word_o.is_synced)
    else $error("synced status without sync flag");

  a_packet_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_SYNCED |-> out_word_o.packet_micros == '0)
    else $error("packet time on a word that did not sync");

  a_unsynced_now : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_synced |-> out_word_o.server_micros_now == '0)
    else $error("server time reported while unsynced");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PacketBytes)
    else $error("byte count past packet length");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_vld_q && b_vld_q && c_vld_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  a_sync_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(synced_q) |-> synced_q)
    else $error("sync flag dropped");

endmodule

// ----- bench/tb_ntp_response_time_sync.sv -----
`timescale 1ns / 100ps
// tb_ntp_response_time_sync: self-checking bench for the sntp time sync block
// drives event words and apb writes, predicts each result word and compares it
// depends on ntpts_pkg and design/ntp_response_time_sync.sv
module tb_ntp_response_time_sync;
  import ntpts_pkg::*;

  localparam logic [AddrW-1:0] MinUnixAddr = {RegMinUnix, 2'b00};
  localparam logic [AddrW-1:0] UnusedAddr  = MinUnixAddr + 3'd4;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 10;

  logic        clk_i;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready_o;
  in_word_t    in_word;
  logic        out_valid_o;
  logic        out_ready;
  out_word_t   out_word_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ntp_response_time_sync u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predictor copy of the block state
  logic [31:0] min_secs;
  logic [5:0]  pkt_len;
  logic        pkt_mode_good;
  logic [31:0] tx_seconds;
  logic [31:0] tx_fraction;
  logic [63:0] req_stamp;
  logic [63:0] resp_stamp;
  logic [63:0] srv_at_sync;
  logic [63:0] loc_at_sync;
  logic [63:0] rtt_at_sync;
  logic        have_sync;

  out_word_t pending_results[$];

  int errors;
  int mismatches;
  int words_sent;
  int results_checked;
  int cfg_writes;
  int status_seen[0:7];
  int burst_left;
  int stall_left;
  int rx_mode;
  int rx_cycles;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor: one event word in, one result word out, state updated on the way
  // ---------------------------------------------------------------------------
  function automatic out_word_t predict_event(input in_word_t w);
    out_word_t   r;
    logic [31:0] unix_s;
    logic [63:0] us;
    logic [63:0] rtt;
    r = '0;
    r.status = ST_NONE;
    case (w.opcode)
      OP_REQUEST:  req_stamp  = w.local_micros;
      OP_RESPONSE: resp_stamp = w.local_micros;
      OP_BYTE: begin
        // bytes past the 48th are not counted and carry nothing
        if (pkt_len < PacketBytes) begin
          if (pkt_len == ModeByte)
            pkt_mode_good = (w.data_byte[2:0] == ServerMode);
          if (pkt_len >= SecondsFirst && pkt_len <= SecondsLast)
            tx_seconds = {tx_seconds[23:0], w.data_byte};
          if (pkt_len >= FracFirst && pkt_len <= FracLast)
            tx_fraction = {tx_fraction[23:0], w.data_byte};
          pkt_len = pkt_len + 6'd1;
        end
        if (w.last_byte) begin
          // length first, then mode, then age
          if (pkt_len < PacketBytes) begin
            r.status = ST_SHORT;
          end else if (!pkt_mode_good) begin
            r.status = ST_BAD_MODE;
          end else begin
            unix_s = tx_seconds - EpochGapSeconds;
            if (unix_s < min_secs) begin
              r.status = ST_TOO_OLD;
            end else begin
              us = 64'(unix_s) * 64'(MicrosPerSecond)
                 + ((64'(tx_fraction) * 64'(MicrosPerSecond)) >> 32);
              rtt = resp_stamp - req_stamp;
              r.packet_micros = us;
              srv_at_sync = us + (rtt >> 1);
              loc_at_sync = resp_stamp;
              rtt_at_sync = rtt;
              have_sync = 1'b1;
              r.status = ST_SYNCED;
            end
          end
          pkt_len = '0;
          pkt_mode_good = 1'b0;
          tx_seconds = '0;
          tx_fraction = '0;
        end
      end
      default: ;  // time query only reports
    endcase
    r.is_synced = have_sync;
    if (have_sync) begin
      r.server_micros_at_sync = srv_at_sync;
      r.local_micros_at_sync  = loc_at_sync;
      r.server_micros_now     = srv_at_sync + (w.local_micros - loc_at_sync);
      r.round_trip_micros     = rtt_at_sync;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: bursts of words with random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    int gap;
    out_word_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // about a quarter of bursts follow the previous one with no gap
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_event(w);
    status_seen[r.status]++;
    pending_results.push_back(r);
    words_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // hold off until every expected result word has come back, then let the
  // pipeline settle
  task automatic drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_time();
    case ($urandom_range(0, 4))
      0:       return 64'($urandom_range(0, 1000));
      1:       return '1 - 64'($urandom_range(0, 1000));
      2:       return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // non-byte events carry random data and last flags, which must be ignored
  task automatic send_event(input opcode_e op, input logic [63:0] t);
    in_word_t w;
    w.opcode       = op;
    w.local_micros = t;
    w.data_byte    = 8'($urandom);
    w.last_byte    = 1'($urandom);
    send_word(w);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [63:0] t);
    in_word_t w;
    w.opcode       = OP_BYTE;
    w.local_micros = t;
    w.data_byte    = b;
    w.last_byte    = last;
    send_word(w);
  endtask

  // one packet: mode byte first, big-endian transmit stamp in bytes 40..47,
  // random filler elsewhere; queries may be mixed in between bytes
  task automatic send_packet(input int len, input logic [7:0] mode_b,
                             input logic [31:0] secs, input logic [31:0] frac,
                             input bit mark_last, input bit mix_in,
                             input logic [63:0] base_t);
    logic [7:0]  b;
    logic [63:0] t;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0) b = mode_b;
      if (i >= 40 && i <= 43) b = secs[8*(43-i) +: 8];
      if (i >= 44 && i <= 47) b = frac[8*(47-i) +: 8];
      t = ($urandom_range(0, 15) == 0) ? rand_time() : base_t + 64'(8 * i);
      if (mix_in && $urandom_range(0, 29) == 0)
        send_event(OP_QUERY, t);
      send_byte(b, mark_last && (i == len - 1), t);
    end
  endtask

  function automatic logic [7:0] good_mode();
    logic [7:0] b;
    b = 8'($urandom);
    b[2:0] = ServerMode;
    return b;
  endfunction

  function automatic logic [7:0] bad_mode();
    logic [7:0] b;
    b = 8'($urandom);
    if (b[2:0] == ServerMode) b[0] = ~b[0];
    return b;
  endfunction

  // ntp seconds whose unix value is no older than the current minimum
  function automatic logic [31:0] fresh_secs();
    logic [31:0] unix_s;
    unix_s = min_secs + 32'(64'($urandom) % (64'h1_0000_0000 - 64'(min_secs)));
    return unix_s + EpochGapSeconds;
  endfunction

  function automatic logic [31:0] stale_secs();
    return 32'($urandom % min_secs) + EpochGapSeconds;
  endfunction

  // ---------------------------------------------------------------------------
  // apb register access, only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // unknown register indexes are ignored
    if (addr == MinUnixAddr) min_secs = data;
    cfg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_min_register();
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MinUnixAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got !== min_secs) begin
      errors++;
      $display("register read: expected %0d, got %0d", min_secs, got);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_min_secs(input logic [31:0] value);
    drain();
    apb_write(MinUnixAddr, value);
    check_min_register();
  endtask

  // ---------------------------------------------------------------------------
  // output side: stall pattern, then the result checker
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      case (rx_mode)
        1: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 3);
        2: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
        default: ;  // no stalls in this stretch
      endcase
    end
    rx_cycles++;
    if (rx_cycles % 300 == 0) rx_mode = $urandom_range(0, 2);
  end

  always @(posedge clk_i) begin
    out_word_t exp;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches < MaxReports)
          $display("result word with nothing expected: %h", out_word_o);
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        results_checked++;
        if (out_word_o.status !== exp.status
            || out_word_o.is_synced !== exp.is_synced
            || out_word_o.packet_micros !== exp.packet_micros
            || out_word_o.server_micros_at_sync !== exp.server_micros_at_sync
            || out_word_o.local_micros_at_sync !== exp.local_micros_at_sync
            || out_word_o.server_micros_now !== exp.server_micros_now
            || out_word_o.round_trip_micros !== exp.round_trip_micros) begin
          errors++;
          if (mismatches < MaxReports) begin
            $display("mismatch on result %0d", results_checked);
            $display("  status     exp %0d got %0d", exp.status, out_word_o.status);
            $display("  synced     exp %0d got %0d", exp.is_synced, out_word_o.is_synced);
            $display("  packet     exp %h got %h", exp.packet_micros,
                     out_word_o.packet_micros);
            $display("  srv@sync   exp %h got %h", exp.server_micros_at_sync,
                     out_word_o.server_micros_at_sync);
            $display("  loc@sync   exp %h got %h", exp.local_micros_at_sync,
                     out_word_o.local_micros_at_sync);
            $display("  srv now    exp %h got %h", exp.server_micros_now,
                     out_word_o.server_micros_now);
            $display("  round trip exp %h got %h", exp.round_trip_micros,
                     out_word_o.round_trip_micros);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value, and a write to an unused index that must change nothing
  task automatic test_register_access();
    check_min_register();
    apb_write(UnusedAddr, $urandom);
    check_min_register();
  endtask

  // events before any sync, with extreme times and ignored fields set
  task automatic test_unsynced_events();
    send_event(OP_QUERY, '0);
    send_event(OP_QUERY, '1);
    send_event(OP_REQUEST, '1);
    send_event(OP_RESPONSE, '0);
    send_byte(8'hff, 1'b1, '1);       // one-byte packet, too short
    send_byte(8'h00, 1'b1, '0);
  endtask

  // each outcome of packet judgement, plus the long and unmatched cases
  task automatic test_packet_judgement();
    send_packet(47, good_mode(), fresh_secs(), $urandom, 1, 0, 64'd100);
    send_packet(48, bad_mode(), fresh_secs(), $urandom, 1, 0, 64'd200);
    send_packet(48, good_mode(), EpochGapSeconds + min_secs - 32'd1, '1, 1, 0, '1);
    // no fresh request or response: judged with the stamps held from earlier
    send_packet(48, good_mode(), '1, '1, 1, 0, 64'd300);
    send_event(OP_QUERY, '1);
    // long packet: bytes past 48 ignored, stamp of zero wraps to a recent date
    send_event(OP_REQUEST, 64'd1000);
    send_event(OP_RESPONSE, 64'd1777);
    send_packet(53, good_mode(), '0, '0, 1, 0, 64'd2000);
    send_event(OP_QUERY, '0);
  endtask

  // both ends of the minimum seconds range
  task automatic test_min_extremes();
    set_min_secs('0);
    send_packet(48, good_mode(), EpochGapSeconds, '0, 1, 0, 64'd5000);
    set_min_secs('1);
    send_packet(48, good_mode(), EpochGapSeconds - 32'd1, '1, 1, 0, 64'd6000);
    send_packet(48, good_mode(), EpochGapSeconds - 32'd2, $urandom, 1, 0, '1);
  endtask

  // request, response, packet, then a few queries; mostly well formed
  task automatic run_exchange();
    logic [63:0] t_req;
    logic [63:0] t_resp;
    int kind;
    t_req  = rand_time();
    t_resp = ($urandom_range(0, 7) == 0) ? rand_time()
           : t_req + 64'($urandom_range(0, 200000));
    // close off any packet left half done by noise
    if (pkt_len != 0) send_byte(8'($urandom), 1'b1, rand_time());
    if ($urandom_range(0, 5) != 0) send_event(OP_REQUEST, t_req);
    if ($urandom_range(0, 5) != 0) send_event(OP_RESPONSE, t_resp);
    kind = $urandom_range(0, 9);
    if (kind == 9 && min_secs == 0) kind = 0;
    case (kind)
      6: send_packet($urandom_range(49, 60), good_mode(), fresh_secs(), $urandom,
                     1, 1, t_resp);
      7: send_packet($urandom_range(1, 47), good_mode(), fresh_secs(), $urandom,
                     1, 1, t_resp);
      8: send_packet(48, bad_mode(), fresh_secs(), $urandom, 1, 1, t_resp);
      9: send_packet(48, good_mode(), stale_secs(), $urandom, 1, 1, t_resp);
      default: send_packet(48, good_mode(), fresh_secs(), $urandom, 1, 1, t_resp);
    endcase
    repeat ($urandom_range(0, 3))
      send_event(OP_QUERY, ($urandom_range(0, 1) == 0) ? rand_time()
                           : t_resp + 64'($urandom));
  endtask

  task automatic run_noise();
    in_word_t w;
    repeat ($urandom_range(1, 8)) begin
      w.opcode       = opcode_e'($urandom_range(0, 3));
      w.local_micros = rand_time();
      w.data_byte    = 8'($urandom);
      w.last_byte    = 1'($urandom);
      send_word(w);
    end
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_exchange();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    min_secs   = MinUnixReset;
    pkt_len    = '0;
    pkt_mode_good = 1'b0;
    tx_seconds = '0;
    tx_fraction = '0;
    req_stamp  = '0;
    resp_stamp = '0;
    srv_at_sync = '0;
    loc_at_sync = '0;
    rtt_at_sync = '0;
    have_sync  = 1'b0;
    errors = 0; mismatches = 0; words_sent = 0; results_checked = 0;
    cfg_writes = 0; burst_left = 0; stall_left = 0; rx_mode = 0;
    rx_cycles = 0; idle_cycles = 0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    test_register_access();
    test_unsynced_events();
    test_packet_judgement();
    test_min_extremes();

    // random traffic under several minimum settings; each change waits for
    // the pipeline to empty first
    set_min_secs(MinUnixReset);
    test_random_traffic(250);
    set_min_secs('0);
    test_random_traffic(250);
    set_min_secs($urandom_range(32'd900000000, 32'd2000000000));
    test_random_traffic(250);
    set_min_secs('1);
    test_random_traffic(50);
    set_min_secs($urandom_range(32'd0, 32'd1500000000));
    test_random_traffic(100);

    drain();
    if (pending_results.size() != 0) errors++;

    $display("covered %0d event words and %0d result words over %0d register writes",
             words_sent, results_checked, cfg_writes);
    $display("outcomes: synced %0d, short %0d, bad mode %0d, too old %0d, none %0d",
             status_seen[ST_SYNCED], status_seen[ST_SHORT], status_seen[ST_BAD_MODE],
             status_seen[ST_TOO_OLD], status_seen[ST_NONE]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ntpts_pkg.sv
design/ntp_response_time_sync.sv
bench/tb_ntp_response_time_sync.sv
